FILE: src/vertex_fp_mul_rcp_rsqrt_unit_defines.svh
// Assertion macros used by the unit's top-level RTL file.
`ifndef VERTEX_FP_MUL_RCP_RSQRT_UNIT_DEFINES_SVH
`define VERTEX_FP_MUL_RCP_RSQRT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define VFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define VFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/vfu_pkg.sv
package vfu_pkg;

  // Operation codes carried in tuser.
  localparam logic [1:0] FN_MUL  = 2'd0;
  localparam logic [1:0] FN_RCP  = 2'd1;
  localparam logic [1:0] FN_RCPC = 2'd2;
  localparam logic [1:0] FN_RSQ  = 2'd3;

  localparam logic [31:0] QNAN_OUT = 32'h7fff_ffff;
  localparam logic [31:0] PINF_OUT = 32'h7f80_0000;
  localparam logic [7:0]  EXP_MAX  = 8'hfe;
  localparam logic [7:0]  EXP_CLO  = 8'h3f;
  localparam logic [7:0]  EXP_CHI  = 8'hbf;
  localparam logic [7:0]  EXP_BIAS = 8'h7f;

  // Where the fraction field of a result comes from.
  typedef enum logic [1:0] {FS_NONE, FS_RCP, FS_RSQ, FS_MUL} fsel_e;

  typedef struct packed {
    logic [31:0] base;
    fsel_e       sel;
  } vfu_tag_t;

  // Seeds and first products handed to the iteration core.
  typedef struct packed {
    logic [23:0] rcp_x;
    logic [6:0]  rcp_s0;
    logic [30:0] rcp_m1;
    logic [24:0] rsq_x;
    logic [6:0]  rsq_s0;
    logic [13:0] rsq_sq;
  } vfu_seed_t;

  localparam logic [5:0] RCP_SEED [64] = '{
    6'h3f, 6'h3d, 6'h3b, 6'h39, 6'h37, 6'h35, 6'h34, 6'h32,
    6'h30, 6'h2f, 6'h2d, 6'h2c, 6'h2b, 6'h29, 6'h28, 6'h27,
    6'h25, 6'h24, 6'h23, 6'h22, 6'h20, 6'h1f, 6'h1e, 6'h1d,
    6'h1c, 6'h1b, 6'h1a, 6'h19, 6'h18, 6'h17, 6'h16, 6'h15,
    6'h14, 6'h14, 6'h13, 6'h12, 6'h11, 6'h10, 6'h0f, 6'h0f,
    6'h0e, 6'h0d, 6'h0c, 6'h0c, 6'h0b, 6'h0a, 6'h0a, 6'h09,
    6'h08, 6'h08, 6'h07, 6'h06, 6'h06, 6'h05, 6'h05, 6'h04,
    6'h03, 6'h03, 6'h02, 6'h02, 6'h01, 6'h01, 6'h00, 6'h00
  };

  localparam logic [5:0] RSQ_SEED [128] = '{
    6'h3f, 6'h3e, 6'h3d, 6'h3c, 6'h3b, 6'h3a, 6'h39, 6'h39,
    6'h38, 6'h37, 6'h36, 6'h35, 6'h35, 6'h34, 6'h33, 6'h32,
    6'h32, 6'h31, 6'h30, 6'h30, 6'h2f, 6'h2e, 6'h2e, 6'h2d,
    6'h2c, 6'h2c, 6'h2b, 6'h2b, 6'h2a, 6'h29, 6'h29, 6'h28,
    6'h28, 6'h27, 6'h27, 6'h26, 6'h26, 6'h25, 6'h25, 6'h24,
    6'h24, 6'h23, 6'h23, 6'h22, 6'h22, 6'h21, 6'h21, 6'h20,
    6'h20, 6'h20, 6'h1f, 6'h1f, 6'h1e, 6'h1e, 6'h1e, 6'h1d,
    6'h1d, 6'h1c, 6'h1c, 6'h1c, 6'h1b, 6'h1b, 6'h1b, 6'h1a,
    6'h1a, 6'h19, 6'h18, 6'h18, 6'h17, 6'h16, 6'h16, 6'h15,
    6'h15, 6'h14, 6'h13, 6'h13, 6'h12, 6'h12, 6'h11, 6'h11,
    6'h10, 6'h10, 6'h0f, 6'h0f, 6'h0e, 6'h0e, 6'h0d, 6'h0d,
    6'h0c, 6'h0c, 6'h0c, 6'h0b, 6'h0b, 6'h0a, 6'h0a, 6'h0a,
    6'h09, 6'h09, 6'h08, 6'h08, 6'h08, 6'h07, 6'h07, 6'h07,
    6'h06, 6'h06, 6'h06, 6'h05, 6'h05, 6'h05, 6'h04, 6'h04,
    6'h04, 6'h03, 6'h03, 6'h03, 6'h03, 6'h02, 6'h02, 6'h02,
    6'h01, 6'h01, 6'h01, 6'h01, 6'h00, 6'h00, 6'h00, 6'h00
  };

endpackage

FILE: src/vfu_nr_core.sv
module vfu_nr_core (
  input  logic              clk,
  input  logic              en,
  input  vfu_pkg::vfu_seed_t seed_i,
  output logic [22:0]       rcp_frac_o,
  output logic [22:0]       rsq_frac_o
);
  import vfu_pkg::*;

  // Reciprocal path registers.
  logic [13:0] r2_s1_r, r3_s1_r;
  logic [23:0] r2_x_r;
  logic [37:0] r3_sx_r;
  logic [22:0] r4_frac_r, r5_frac_r, r6_frac_r;
  // Rsqrt path registers.
  logic [38:0] q2_m_r;
  logic [6:0]  q2_s0_r;
  logic [24:0] q2_x_r, q3_x_r, q4_x_r;
  logic [13:0] q3_s1_r, q4_s1_r, q5_s1_r;
  logic [27:0] q4_sq_r;
  logic [52:0] q5_m_r;
  logic [22:0] q6_frac_r;

  logic [38:0] r2_p_nxt;
  logic [47:0] r4_t_nxt, r4_p_nxt;
  logic [45:0] q3_t_nxt, q3_p_nxt;
  logic [61:0] q6_t_nxt, q6_p_nxt;

  // First and second Newton-Raphson steps, one multiply per stage.
  always_comb begin
    r2_p_nxt = 39'((32'h8000_0000 - {1'b0, seed_i.rcp_m1})) * 39'(seed_i.rcp_s0);
    r4_t_nxt = (48'd1 << 37) - 48'(r3_sx_r);
    r4_p_nxt = r4_t_nxt * 48'(r3_s1_r);
    q3_t_nxt = (46'd3 << 37) - 46'(q2_m_r);
    q3_p_nxt = q3_t_nxt * 46'(q2_s0_r);
    q6_t_nxt = (62'd3 << 49) - 62'(q5_m_r);
    q6_p_nxt = q6_t_nxt * 62'(q5_s1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_s1_r   <= r2_p_nxt[37:24];
      r2_x_r    <= seed_i.rcp_x;
      r3_sx_r   <= 38'(r2_s1_r) * 38'(r2_x_r);
      r3_s1_r   <= r2_s1_r;
      r4_frac_r <= r4_p_nxt[47:25];
      r5_frac_r <= r4_frac_r;
      r6_frac_r <= r5_frac_r;
      q2_m_r    <= 39'(seed_i.rsq_sq) * 39'(seed_i.rsq_x);
      q2_s0_r   <= seed_i.rsq_s0;
      q2_x_r    <= seed_i.rsq_x;
      q3_s1_r   <= q3_p_nxt[45:32];
      q3_x_r    <= q2_x_r;
      q4_sq_r   <= 28'(q3_s1_r) * 28'(q3_s1_r);
      q4_s1_r   <= q3_s1_r;
      q4_x_r    <= q3_x_r;
      q5_m_r    <= 53'(q4_sq_r) * 53'(q4_x_r);
      q5_s1_r   <= q4_s1_r;
      q6_frac_r <= q6_p_nxt[61:39];
    end
  end

  assign rcp_frac_o = r6_frac_r;
  assign rsq_frac_o = q6_frac_r;

endmodule

FILE: src/vertex_fp_mul_rcp_rsqrt_unit.sv
// Each accepted input beat passes the vld_r stages and then the output register.
// Throughput: one beat per cycle; stages hold while out_tvalid is high, out_tready low.
// The iteration core sets the depth: each Newton-Raphson step takes a stage per multiply.
// Reset: rst_n is synchronous and active low; it clears the stage valid bits only.
module vertex_fp_mul_rcp_rsqrt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [1:0]  in_tuser,   // func [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result [31:0]
);
  import vfu_pkg::*;
  `include "vertex_fp_mul_rcp_rsqrt_unit_defines.svh"

  logic        en;
  logic [6:1]  vld_r;
  logic        out_tvalid_r;
  logic [31:0] out_data_r, out_data_nxt;

  vfu_tag_t    tag1_r, tag1_nxt, tag2_nxt;
  vfu_tag_t    tag_r [6:2];
  vfu_seed_t   seed_r, seed_nxt;
  logic [47:0] mprod_r;
  logic [9:0]  mexp_r, mexp_nxt;
  logic [22:0] rcp_frac, rsq_frac;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Stage 1: special cases, exponents, seeds and the first products.
  always_comb begin
    logic [31:0] a, b;
    logic [7:0]  ea, eb, rsq_er;
    logic [22:0] fa, fb, rf;
    logic        nan_a, nan_b;
    logic [9:0]  rcp_er, rsq_d;
    logic [23:0] m;
    logic [6:0]  rs0, qs0;
    logic [24:0] qx;
    a      = in_tdata[31:0];
    b      = in_tdata[63:32];
    ea     = a[30:23];
    eb     = b[30:23];
    fa     = a[22:0];
    fb     = b[22:0];
    nan_a  = (ea == 8'hff) && (fa != '0);
    nan_b  = (eb == 8'hff) && (fb != '0);
    mexp_nxt = 10'(ea) + 10'(eb) - 10'(EXP_BIAS);
    tag1_nxt = '{base: '0, sel: FS_NONE};
    rf     = (ea == 8'd0) ? '0 : fa;
    rcp_er = 10'(EXP_MAX) - 10'(ea) - ((rf != '0) ? 10'd1 : 10'd0);
    rsq_d  = 10'(ea) - (ea[0] ? 10'd127 : 10'd128);
    rsq_er = 8'(10'd126 - 10'($signed(rsq_d) >>> 1));
    unique case (in_tuser)
      FN_MUL: begin
        if (nan_a || nan_b) begin
          tag1_nxt.base = QNAN_OUT;
        end else if (ea == 8'd0 || eb == 8'd0) begin
          tag1_nxt.base = '0;
        end else if (ea == 8'hff || eb == 8'hff) begin
          tag1_nxt.base = PINF_OUT;
        end else begin
          tag1_nxt.base = {a[31] ^ b[31], 31'd0};
          tag1_nxt.sel  = FS_MUL;
        end
      end
      FN_RCP: begin
        if (nan_a) begin
          tag1_nxt.base = QNAN_OUT;
        end else if (ea == 8'd0) begin
          tag1_nxt.base = PINF_OUT;
        end else if ($signed(rcp_er) <= 0) begin
          tag1_nxt.base = {a[31], 31'd0};
        end else begin
          tag1_nxt.base = {a[31], rcp_er[7:0], 23'd0};
          tag1_nxt.sel  = (rf != '0) ? FS_RCP : FS_NONE;
        end
      end
      FN_RCPC: begin
        if (nan_a) begin
          tag1_nxt.base = QNAN_OUT;
        end else begin
          if ($signed(rcp_er) < $signed(10'(EXP_CLO))) begin
            tag1_nxt.base = {a[31], EXP_CLO, 23'd0};
          end else if ($signed(rcp_er) > $signed(10'(EXP_CHI))) begin
            tag1_nxt.base = {a[31], EXP_CHI, 23'd0};
          end else begin
            tag1_nxt.base = {a[31], rcp_er[7:0], 23'd0};
          end
          tag1_nxt.sel = (rf != '0) ? FS_RCP : FS_NONE;
        end
      end
      FN_RSQ: begin
        if (nan_a) begin
          tag1_nxt.base = QNAN_OUT;
        end else if (ea == 8'd0 || a[31]) begin
          tag1_nxt.base = PINF_OUT;
        end else if (ea == 8'hff) begin
          tag1_nxt.base = '0;
        end else begin
          tag1_nxt.base = {1'b0, rsq_er, 23'd0};
          tag1_nxt.sel  = FS_RSQ;
        end
      end
      default: tag1_nxt = '{base: '0, sel: FS_NONE};
    endcase
    // Seeds: odd exponents use the plain fraction, even ones set bit 23.
    rs0 = {1'b1, RCP_SEED[fa[22:17]]};
    m   = ea[0] ? {1'b0, fa} : {1'b1, fa};
    qs0 = {1'b1, RSQ_SEED[m[23:17]]};
    qx  = m[23] ? {m, 1'b0} : 25'(m) + 25'h80_0000;
    seed_nxt.rcp_x  = {1'b1, fa};
    seed_nxt.rcp_s0 = rs0;
    seed_nxt.rcp_m1 = 31'(rs0) * 31'({1'b1, fa});
    seed_nxt.rsq_x  = qx;
    seed_nxt.rsq_s0 = qs0;
    seed_nxt.rsq_sq = 14'(qs0) * 14'(qs0);
  end

  // Stage 2: normalize the truncated product, saturate overflow, flush underflow to zero.
  always_comb begin
    logic [24:0] p;
    logic [9:0]  e;
    logic [22:0] f;
    p = mprod_r[47:23];
    if (p[24]) begin
      f = p[23:1];
      e = mexp_r + 10'd1;
    end else begin
      f = p[22:0];
      e = mexp_r;
    end
    tag2_nxt = tag1_r;
    if (tag1_r.sel == FS_MUL) begin
      tag2_nxt.sel = FS_NONE;
      if ($signed(e) <= 0) begin
        tag2_nxt.base = {tag1_r.base[31], 31'd0};
      end else if ($signed(e) >= $signed(10'd255)) begin
        tag2_nxt.base = {tag1_r.base[31], EXP_MAX, 23'h7f_ffff};
      end else begin
        tag2_nxt.base = {tag1_r.base[31], e[7:0], f};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r   <= tag1_nxt;
      seed_r   <= seed_nxt;
      mexp_r   <= mexp_nxt;
      mprod_r  <= 48'({1'b1, in_tdata[22:0]}) * 48'({1'b1, in_tdata[54:32]});
      tag_r[2] <= tag2_nxt;
      tag_r[3] <= tag_r[2];
      tag_r[4] <= tag_r[3];
      tag_r[5] <= tag_r[4];
      tag_r[6] <= tag_r[5];
      out_data_r <= out_data_nxt;
    end
  end

  vfu_nr_core u_core (
    .clk        (clk),
    .en         (en),
    .seed_i     (seed_r),
    .rcp_frac_o (rcp_frac),
    .rsq_frac_o (rsq_frac)
  );

  // Output stage: merge the refined fraction into the result word.
  always_comb begin
    out_data_nxt = tag_r[6].base;
    unique case (tag_r[6].sel)
      FS_RCP:  out_data_nxt = {tag_r[6].base[31:23], rcp_frac};
      FS_RSQ:  out_data_nxt = {tag_r[6].base[31:23], rsq_frac};
      default: out_data_nxt = tag_r[6].base;
    endcase
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[5:1], in_tvalid};
      out_tvalid_r <= vld_r[6];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `VFU_ASSERT_NEXT(a_hold_valid, !en, $stable(vld_r))
  `VFU_ASSERT_NEXT(a_enter, in_tvalid && in_tready, vld_r[1])
  `VFU_ASSERT_NEXT(a_drain, vld_r[6] && en, out_tvalid)
  `VFU_ASSERT_NOW(a_no_mul_tag, vld_r[2], tag_r[2].sel != FS_MUL)

endmodule
